/* hw/rtl/ata_pio_sector_transfer_assert.svh */
// assertion macros for the ata pio sequencer checker
// no dependencies
`ifndef ATA_PIO_SECTOR_TRANSFER_ASSERT_SVH
`define ATA_PIO_SECTOR_TRANSFER_ASSERT_SVH
// implication checked every clock outside reset
`define APST_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define APST_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/apst_pkg.sv */
// shared types, codes and constants of the ata pio sequencer
// no dependencies
`default_nettype none
package apst_pkg;
  localparam int unsigned PollLimit      = 100000;
  localparam int unsigned ReadyPollLimit = 5000;
  localparam int unsigned PollW          = 17;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_BURST  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_WREG     = 3'd0,
    ACT_STATUS   = 3'd1,
    ACT_BURST_RD = 3'd2,
    ACT_BURST_WR = 3'd3,
    ACT_DONE     = 3'd4,
    ACT_FAIL     = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    FAIL_NONE    = 2'd0,
    FAIL_NOTRDY  = 2'd1,
    FAIL_DRIVE   = 2'd2,
    FAIL_TIMEOUT = 2'd3
  } fail_e;

  typedef enum logic [2:0] {
    REG_USE_LBA  = 3'd0,
    REG_CAPACITY = 3'd1,
    REG_HEADS    = 3'd2,
    REG_SPT      = 3'd3,
    REG_DRIVE    = 3'd4
  } cfg_idx_e;

  // controller phase
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_READY,
    PH_DRQ,
    PH_BURST,
    PH_FINAL,
    PH_DIV,    // chs divide in progress
    PH_EMIT,   // emitting task file sequence
    PH_OUT     // single result waiting
  } phase_e;

  localparam logic [7:0] StBsy  = 8'h80;
  localparam logic [7:0] StDrdy = 8'h40;
  localparam logic [7:0] StDrq  = 8'h08;
  localparam logic [7:0] StErr  = 8'h01;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] block_address;
    logic [7:0]  sector_count;
    logic [7:0]  status_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] reg_address;
    logic [7:0] reg_value;
    logic [7:0] sectors_done;
    logic [1:0] fault_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        use_lba;
    logic [31:0] capacity;
    logic [4:0]  heads;
    logic [7:0]  spt;
    logic        drive;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic start;     // latch address and start chs divide
    logic [3:0] step; // task file emit step
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       div_done;
    logic [2:0] reg_address;
    logic [7:0] reg_value;
    logic       seq_last; // step is the command byte
  } dp_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/ata_pio_sector_transfer.sv */
// ata pio sector sequencer: one request in, results out through one output register
// a result is registered and shows in the cycle after its request; the next request
// is taken in the cycle after the last result is taken
// the chs divider starts on a read or write request; a ready status request waits
// for it, then its 7 or 11 results follow one per cycle while the output drains
// async active-low reset: idle phase, config registers to their defaults
`default_nettype none
module ata_pio_sector_transfer (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  apst_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output apst_pkg::out_item_t  out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [2:0]           cfg_index_i,
  input  wire  [31:0]          cfg_data_i
);
  apst_pkg::cfg_t     cfg_q;
  apst_pkg::dp_cmd_t  dp_cmd;
  apst_pkg::dp_stat_t dp_stat;

  // config writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_lba  <= 1'b1;
      cfg_q.capacity <= 32'd0;
      cfg_q.heads    <= 5'd16;
      cfg_q.spt      <= 8'd63;
      cfg_q.drive    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        apst_pkg::REG_USE_LBA:  cfg_q.use_lba  <= cfg_data_i[0];
        apst_pkg::REG_CAPACITY: cfg_q.capacity <= cfg_data_i;
        apst_pkg::REG_HEADS:    cfg_q.heads    <= cfg_data_i[4:0];
        apst_pkg::REG_SPT:      cfg_q.spt      <= cfg_data_i[7:0];
        apst_pkg::REG_DRIVE:    cfg_q.drive    <= cfg_data_i[0];
        default: ; // unmapped index ignored
      endcase
    end
  end

  // controller: phases, polls, result register
  apst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .dp_cmd_o(dp_cmd), .dp_stat_i(dp_stat)
  );

  // datapath: address latch, divider, task file bytes
  apst_datapath u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .lba_i(in_data_i.block_address), .count_i(in_data_i.sector_count),
    .is_write_i(in_data_i.command[0]),
    .cmd_i(dp_cmd), .stat_o(dp_stat)
  );
endmodule
`default_nettype wire

/* hw/rtl/apst_datapath.sv */
// address latch, chs divider and task file sequence generator
// depends on apst_pkg
`default_nettype none
module apst_datapath (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  apst_pkg::cfg_t         cfg_i,
  input  wire  [31:0]            lba_i,
  input  wire  [7:0]             count_i,
  input  wire                    is_write_i,
  input  apst_pkg::dp_cmd_t      cmd_i,
  output apst_pkg::dp_stat_t     stat_o
);
  logic [31:0] lba_q, lba_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        wr_q, wr_d;
  // restoring divider: rem, quotient, divisor, bit counter, pass
  logic [31:0] quo_q, quo_d;
  logic [7:0]  rem_q, rem_d;
  logic [5:0]  bit_q, bit_d;
  logic        pass_q, pass_d;
  logic        busy_q, busy_d;
  logic [7:0]  sec_q, sec_d;
  logic [3:0]  head_q, head_d;
  logic [8:0]  trial;
  logic [7:0]  divisor;
  logic        wide;
  logic [7:0]  base;

  assign wide = cfg_i.use_lba && (cfg_i.capacity > 32'h0FFF_FFFF);
  assign base = cfg_i.drive ? 8'hB0 : 8'hA0;

  always_comb begin
    if (!pass_q) divisor = (cfg_i.spt == 8'd0) ? 8'd1 : cfg_i.spt;
    else         divisor = (cfg_i.heads == 5'd0) ? 8'd1 : {3'd0, cfg_i.heads};
  end

  always_comb begin
    lba_d  = lba_q;  cnt_d = cnt_q; wr_d = wr_q;
    quo_d  = quo_q;  rem_d = rem_q; bit_d = bit_q;
    pass_d = pass_q; busy_d = busy_q;
    sec_d  = sec_q;  head_d = head_q;
    trial  = {rem_q, quo_q[31]};
    if (cmd_i.start) begin
      lba_d = lba_i; cnt_d = count_i; wr_d = is_write_i;
      quo_d = lba_i; rem_d = 8'd0; bit_d = 6'd0; pass_d = 1'b0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor}) begin
        rem_d = 8'(trial - {1'b0, divisor});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      bit_d = bit_q + 6'd1;
      if (bit_q == 6'd31) begin
        if (!pass_q) begin
          sec_d  = 8'(rem_d + 8'd1);
          pass_d = 1'b1; bit_d = 6'd0; rem_d = 8'd0;
        end else begin
          head_d = rem_d[3:0];
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pass_q <= 1'b0;
      bit_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      pass_q <= pass_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lba_q <= lba_d; cnt_q <= cnt_d; wr_q <= wr_d;
    quo_q <= quo_d; rem_q <= rem_d;
    sec_q <= sec_d; head_q <= head_d;
  end

  // step -> register write; quo_q holds cylinder after the second pass
  always_comb begin
    stat_o.div_done    = !busy_q;
    stat_o.reg_address = 3'd0;
    stat_o.reg_value   = 8'd0;
    stat_o.seq_last    = 1'b0;
    if (!cfg_i.use_lba) begin
      unique case (cmd_i.step)
        4'd0: begin stat_o.reg_address = 3'd2; stat_o.reg_value = cnt_q; end
        4'd1: begin stat_o.reg_address = 3'd3; stat_o.reg_value = sec_q; end
        4'd2: begin stat_o.reg_address = 3'd4; stat_o.reg_value = quo_q[7:0]; end
        4'd3: begin stat_o.reg_address = 3'd5; stat_o.reg_value = quo_q[15:8]; end
        4'd4: begin stat_o.reg_address = 3'd6; stat_o.reg_value = base | {4'd0, head_q}; end
        default: begin
          stat_o.reg_address = 3'd7; stat_o.seq_last = 1'b1;
        end
      endcase
    end else if (!wide) begin
      unique case (cmd_i.step)
        4'd0: begin stat_o.reg_address = 3'd2; stat_o.reg_value = cnt_q; end
        4'd1: begin stat_o.reg_address = 3'd3; stat_o.reg_value = lba_q[7:0]; end
        4'd2: begin stat_o.reg_address = 3'd4; stat_o.reg_value = lba_q[15:8]; end
        4'd3: begin stat_o.reg_address = 3'd5; stat_o.reg_value = lba_q[23:16]; end
        4'd4: begin
          stat_o.reg_address = 3'd6;
          stat_o.reg_value   = base | 8'h40 | {4'd0, lba_q[27:24]};
        end
        default: begin
          stat_o.reg_address = 3'd7; stat_o.seq_last = 1'b1;
        end
      endcase
    end else begin
      unique case (cmd_i.step)
        4'd0: begin stat_o.reg_address = 3'd2; end
        4'd1: begin stat_o.reg_address = 3'd3; stat_o.reg_value = lba_q[31:24]; end
        4'd2: begin stat_o.reg_address = 3'd4; end
        4'd3: begin stat_o.reg_address = 3'd5; end
        4'd4: begin stat_o.reg_address = 3'd2; stat_o.reg_value = cnt_q; end
        4'd5: begin stat_o.reg_address = 3'd3; stat_o.reg_value = lba_q[7:0]; end
        4'd6: begin stat_o.reg_address = 3'd4; stat_o.reg_value = lba_q[15:8]; end
        4'd7: begin stat_o.reg_address = 3'd5; stat_o.reg_value = lba_q[23:16]; end
        4'd8: begin stat_o.reg_address = 3'd6; stat_o.reg_value = base | 8'h40; end
        default: begin
          stat_o.reg_address = 3'd7; stat_o.seq_last = 1'b1;
        end
      endcase
    end
    if (stat_o.seq_last) begin
      unique case ({wr_q, wide})
        2'b00: stat_o.reg_value = 8'h20;
        2'b01: stat_o.reg_value = 8'h24;
        2'b10: stat_o.reg_value = 8'h30;
        default: stat_o.reg_value = 8'h34;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/apst_ctrl.sv */
// sequencer state machine: phases, poll counting, result emission
// depends on apst_pkg
`default_nettype none
module apst_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  apst_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output apst_pkg::out_item_t  out_data_o,
  output apst_pkg::dp_cmd_t    dp_cmd_o,
  input  apst_pkg::dp_stat_t   dp_stat_i
);
  apst_pkg::phase_e phase_q, phase_d;
  // phase to resume after the pending output is taken
  apst_pkg::phase_e ret_q, ret_d;
  logic        is_write_q, is_write_d;
  logic [7:0]  total_q, total_d;
  logic [7:0]  index_q, index_d;
  logic [apst_pkg::PollW-1:0] poll_q, poll_d;
  logic [3:0]  step_q, step_d;
  logic        tail_q, tail_d; // pending result is followed by a fail
  apst_pkg::out_item_t ob_q, ob_d;
  logic        ov_q, ov_d;
  logic        acc;
  logic [apst_pkg::PollW-1:0] poll_inc;
  logic [7:0]  st;
  logic [7:0]  idx_inc;

  assign in_ready_o  = !ov_q && (phase_q != apst_pkg::PH_DIV) &&
                       (phase_q != apst_pkg::PH_EMIT) && (phase_q != apst_pkg::PH_OUT);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;
  assign poll_inc    = poll_q + 1'b1;
  assign st          = in_data_i.status_byte;
  assign idx_inc     = index_q + 8'd1;

  function automatic apst_pkg::out_item_t mk(apst_pkg::act_e a, logic [7:0] idx,
                                             apst_pkg::fail_e f, logic l);
    apst_pkg::out_item_t r;
    r.action = a; r.reg_address = 3'd0; r.reg_value = 8'd0;
    r.sectors_done = idx; r.fault_code = f; r.last = l;
    return r;
  endfunction

  always_comb begin
    phase_d = phase_q; ret_d = ret_q; is_write_d = is_write_q;
    total_d = total_q; index_d = index_q; poll_d = poll_q; step_d = step_q;
    tail_d = tail_q; ob_d = ob_q; ov_d = ov_q;
    dp_cmd_o.start = 1'b0;
    dp_cmd_o.step  = step_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (phase_q)
      apst_pkg::PH_DIV: begin
        if (dp_stat_i.div_done) begin
          phase_d = apst_pkg::PH_EMIT; step_d = 4'd0;
        end
      end
      apst_pkg::PH_EMIT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          ob_d = mk(apst_pkg::ACT_WREG, index_q, apst_pkg::FAIL_NONE, 1'b0);
          ob_d.reg_address = dp_stat_i.reg_address;
          ob_d.reg_value   = dp_stat_i.reg_value;
          step_d = step_q + 4'd1;
          if (dp_stat_i.seq_last) begin
            phase_d = apst_pkg::PH_OUT; ret_d = apst_pkg::PH_DRQ; tail_d = 1'b0;
            poll_d = '0;
          end
        end
      end
      apst_pkg::PH_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          phase_d = ret_q;
          ob_d = tail_q ? mk(apst_pkg::ACT_FAIL, index_q, apst_pkg::FAIL_DRIVE, 1'b1)
                        : mk(apst_pkg::ACT_STATUS, index_q, apst_pkg::FAIL_NONE, 1'b1);
        end
      end
      default: begin
        if (acc) begin
          unique case (apst_pkg::cmd_e'(in_data_i.command))
            apst_pkg::CMD_READ, apst_pkg::CMD_WRITE: begin
              is_write_d = in_data_i.command[0];
              total_d = in_data_i.sector_count;
              index_d = 8'd0; poll_d = '0; ov_d = 1'b1;
              if (in_data_i.sector_count == 8'd0) begin
                phase_d = apst_pkg::PH_IDLE;
                ob_d = mk(apst_pkg::ACT_FAIL, 8'd0, apst_pkg::FAIL_NONE, 1'b1);
              end else begin
                phase_d = apst_pkg::PH_READY;
                ob_d = mk(apst_pkg::ACT_STATUS, 8'd0, apst_pkg::FAIL_NONE, 1'b1);
                dp_cmd_o.start = 1'b1;
              end
            end
            apst_pkg::CMD_STATUS: begin
              unique case (phase_q)
                apst_pkg::PH_READY: begin
                  if (((st & apst_pkg::StBsy) == 8'd0) && ((st & apst_pkg::StDrdy) != 8'd0))
                  begin
                    phase_d = apst_pkg::PH_DIV;
                  end else begin
                    ov_d = 1'b1; poll_d = poll_inc;
                    if (poll_inc >= apst_pkg::PollW'(apst_pkg::ReadyPollLimit)) begin
                      phase_d = apst_pkg::PH_IDLE;
                      ob_d = mk(apst_pkg::ACT_FAIL, index_q, apst_pkg::FAIL_NOTRDY, 1'b1);
                    end else
                      ob_d = mk(apst_pkg::ACT_STATUS, index_q, apst_pkg::FAIL_NONE, 1'b1);
                  end
                end
                apst_pkg::PH_DRQ, apst_pkg::PH_FINAL: begin
                  ov_d = 1'b1;
                  if ((st & apst_pkg::StBsy) != 8'd0 ||
                      (phase_q == apst_pkg::PH_DRQ &&
                       (st & (apst_pkg::StErr | apst_pkg::StDrq)) == 8'd0)) begin
                    poll_d = poll_inc;
                    if (poll_inc >= apst_pkg::PollW'(apst_pkg::PollLimit)) begin
                      phase_d = apst_pkg::PH_IDLE;
                      ob_d = mk(apst_pkg::ACT_FAIL, index_q, apst_pkg::FAIL_TIMEOUT,
                                1'b1);
                    end else
                      ob_d = mk(apst_pkg::ACT_STATUS, index_q, apst_pkg::FAIL_NONE, 1'b1);
                  end else if ((st & apst_pkg::StErr) != 8'd0) begin
                    if (phase_q == apst_pkg::PH_DRQ && !is_write_q &&
                        (st & apst_pkg::StDrq) != 8'd0) begin
                      ob_d = mk(apst_pkg::ACT_BURST_RD, index_q, apst_pkg::FAIL_NONE, 1'b0);
                      phase_d = apst_pkg::PH_OUT; ret_d = apst_pkg::PH_IDLE;
                      tail_d = 1'b1;
                    end else begin
                      ob_d = mk(apst_pkg::ACT_FAIL, index_q, apst_pkg::FAIL_DRIVE, 1'b1);
                      phase_d = apst_pkg::PH_IDLE;
                    end
                  end else if (phase_q == apst_pkg::PH_DRQ) begin
                    ob_d = mk(is_write_q ? apst_pkg::ACT_BURST_WR : apst_pkg::ACT_BURST_RD,
                              index_q, apst_pkg::FAIL_NONE, 1'b1);
                    phase_d = apst_pkg::PH_BURST;
                  end else begin
                    ob_d = mk(apst_pkg::ACT_DONE, index_q, apst_pkg::FAIL_NONE, 1'b1);
                    phase_d = apst_pkg::PH_IDLE;
                  end
                end
                default: ;
              endcase
            end
            default: begin
              if (phase_q == apst_pkg::PH_BURST) begin
                index_d = idx_inc; poll_d = '0; ov_d = 1'b1;
                if (idx_inc >= total_q) begin
                  if (is_write_q) begin
                    phase_d = apst_pkg::PH_FINAL;
                    ob_d = mk(apst_pkg::ACT_STATUS, idx_inc, apst_pkg::FAIL_NONE, 1'b1);
                  end else begin
                    phase_d = apst_pkg::PH_IDLE;
                    ob_d = mk(apst_pkg::ACT_DONE, idx_inc, apst_pkg::FAIL_NONE, 1'b1);
                  end
                end else begin
                  phase_d = apst_pkg::PH_DRQ;
                  ob_d = mk(apst_pkg::ACT_STATUS, idx_inc, apst_pkg::FAIL_NONE, 1'b1);
                end
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= apst_pkg::PH_IDLE; ret_q <= apst_pkg::PH_IDLE;
      is_write_q <= 1'b0; total_q <= 8'd0; index_q <= 8'd0;
      poll_q <= '0; step_q <= 4'd0; tail_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; ret_q <= ret_d;
      is_write_q <= is_write_d; total_q <= total_d; index_q <= index_d;
      poll_q <= poll_d; step_q <= step_d; tail_q <= tail_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
  end
endmodule
`default_nettype wire

/* hw/rtl/apst_checker.sv */
// port level checker for the ata pio sequencer, bound to the top level
// depends on apst_pkg and ata_pio_sector_transfer_assert.svh
`default_nettype none
`include "ata_pio_sector_transfer_assert.svh"
module apst_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_ready_o,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input apst_pkg::out_item_t out_data_o
);
  `APST_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `APST_ASSERT_IMP(a_fail_last, clk_i, rst_ni,
    out_valid_o && out_data_o.action == apst_pkg::ACT_FAIL, out_data_o.last)
  `APST_ASSERT_IMP(a_wreg_notlast, clk_i, rst_ni,
    out_valid_o && out_data_o.action == apst_pkg::ACT_WREG, !out_data_o.last)
  `APST_ASSERT_IMP(a_kind_only_fail, clk_i, rst_ni,
    out_valid_o && out_data_o.action != apst_pkg::ACT_FAIL,
    out_data_o.fault_code == apst_pkg::FAIL_NONE)
  `APST_ASSERT_IMP(a_no_in_while_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
endmodule
bind ata_pio_sector_transfer apst_checker u_apst_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
`default_nettype wire
